// ----- rtl/mrtu_pkg.sv -----
// ----------------------------------------------------------------------------
// mrtu_pkg
// Shared types, codes and the CRC-16 byte step for the RTU slave frame engine.
// ----------------------------------------------------------------------------
`default_nettype none

package mrtu_pkg;

  // Input item kinds.
  localparam logic [1:0] KIND_RX_BYTE  = 2'd0;
  localparam logic [1:0] KIND_GAP      = 2'd1;
  localparam logic [1:0] KIND_HOST_WR  = 2'd2;
  localparam logic [1:0] KIND_HOST_RD  = 2'd3;

  // Result kinds.
  localparam logic RES_TX_BYTE = 1'b0;
  localparam logic RES_HOST_RD = 1'b1;

  // Configuration register indexes.
  localparam logic REG_SLAVE_ADDR  = 1'b0;
  localparam logic REG_TABLE_WORDS = 1'b1;

  // Function codes.
  localparam logic [7:0] FC_READ_COILS   = 8'd1;
  localparam logic [7:0] FC_READ_INPUTS  = 8'd2;
  localparam logic [7:0] FC_READ_HOLDING = 8'd3;
  localparam logic [7:0] FC_READ_INPUT_R = 8'd4;
  localparam logic [7:0] FC_WRITE_COIL   = 8'd5;
  localparam logic [7:0] FC_WRITE_REG    = 8'd6;
  localparam logic [7:0] FC_WRITE_COILS  = 8'd15;
  localparam logic [7:0] FC_WRITE_REGS   = 8'd16;

  // Exception codes.
  localparam logic [7:0] EXC_ILLEGAL_FUNC = 8'd1;
  localparam logic [7:0] EXC_ILLEGAL_ADDR = 8'd2;

  localparam logic [7:0]  EXC_FLAG     = 8'h80;
  localparam logic [7:0]  COIL_ON      = 8'hFF;
  localparam logic [7:0]  SLAVE_MAX    = 8'd247;
  localparam logic [15:0] CRC_INIT     = 16'hFFFF;
  localparam logic [15:0] CRC_POLY     = 16'hA001;
  localparam int          MIN_FRAME    = 7;
  localparam int          FIRST_DATA   = 7;
  localparam int          MAX_REPLY    = 64;

  // Frame status handed from the receive side to the sequencer.
  typedef struct packed {
    logic            len_zero;
    logic            len_ok;
    logic            ovf;
    logic            crc_ok;
    logic [5:0][7:0] hdr;
  } frame_info_t;

  // One byte step of the reflected CRC-16.
  function automatic logic [15:0] crc16_byte(input logic [15:0] c_in, input logic [7:0] b);
    logic [15:0] c;
    c = c_in ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/mrtu_rx.sv -----
// ----------------------------------------------------------------------------
// mrtu_rx
// Collects received bytes into the frame store, keeps a running CRC over all
// but the last two bytes, and captures the request header.
// ----------------------------------------------------------------------------
`default_nettype none

module mrtu_rx import mrtu_pkg::*; #(
  parameter int BUFFER_BYTES = 64
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            push,
  input  wire logic [7:0]                      push_byte,
  input  wire logic                            clear,
  input  wire logic                            rd_en,
  input  wire logic [$clog2(BUFFER_BYTES)-1:0] rd_addr,
  output logic      [7:0]                      rd_data,
  output frame_info_t                          info
);

  localparam int LEN_W = $clog2(BUFFER_BYTES + 1);
  localparam int SA_AW = $clog2(BUFFER_BYTES);

  logic [7:0]       store [BUFFER_BYTES];
  logic [LEN_W-1:0] len;
  logic             ovf;
  logic [15:0]      crc;
  logic [7:0]       p1;
  logic [7:0]       p2;
  logic [5:0][7:0]  hdr;
  logic             room;

  assign room = (len < LEN_W'(BUFFER_BYTES));

  // Frame store: written in arrival order, read by the sequencer.
  always_ff @(posedge clk) begin
    if (push && room) begin
      store[len[SA_AW-1:0]] <= push_byte;
    end
    if (rd_en) begin
      rd_data <= store[rd_addr];
    end
  end

  // Last two bytes and the header copy.
  always_ff @(posedge clk) begin
    if (push && room) begin
      p2 <= p1;
      p1 <= push_byte;
      if (len < LEN_W'(6)) begin
        hdr[len[2:0]] <= push_byte;
      end
    end
  end

  // Length, overflow flag and the delayed CRC.
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      len <= '0;
      ovf <= 1'b0;
      crc <= CRC_INIT;
    end else if (push) begin
      if (room) begin
        len <= len + LEN_W'(1);
        if (len >= LEN_W'(2)) begin
          crc <= crc16_byte(crc, p2);
        end
        if (len + LEN_W'(1) >= LEN_W'(BUFFER_BYTES)) begin
          ovf <= 1'b1;
        end
      end else begin
        ovf <= 1'b1;
      end
    end
  end

  assign info.len_zero = (len == '0);
  assign info.len_ok   = (len >= LEN_W'(MIN_FRAME));
  assign info.ovf      = ovf;
  assign info.crc_ok   = (p2 == crc[7:0]) && (p1 == crc[15:8]);
  assign info.hdr      = hdr;

endmodule

`default_nettype wire

// ----- rtl/mrtu_table.sv -----
// ----------------------------------------------------------------------------
// mrtu_table
// Word table memory with one read and one write port and per-word valid bits
// so that the table reads as zero after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module mrtu_table #(
  parameter int TABLE_WORDS = 256
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           rd_en,
  input  wire logic [$clog2(TABLE_WORDS)-1:0] rd_idx,
  output logic      [15:0]                    rd_word,
  input  wire logic                           wr_en,
  input  wire logic [$clog2(TABLE_WORDS)-1:0] wr_idx,
  input  wire logic [15:0]                    wr_word
);

  logic [15:0]            mem [TABLE_WORDS];
  logic [TABLE_WORDS-1:0] valid;
  logic [15:0]            rd_raw;
  logic                   rd_valid;

  // Memory array.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_word;
    end
    if (rd_en) begin
      rd_raw <= mem[rd_idx];
    end
  end

  // Valid bits: cleared at once by reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      rd_valid <= 1'b0;
    end else begin
      if (wr_en) begin
        valid[wr_idx] <= 1'b1;
      end
      if (rd_en) begin
        rd_valid <= valid[rd_idx];
      end
    end
  end

  assign rd_word = rd_valid ? rd_raw : 16'h0000;

endmodule

`default_nettype wire

// ----- rtl/modbus_rtu_slave_frame_engine.sv -----
// ----------------------------------------------------------------------------
// modbus_rtu_slave_frame_engine
// Received byte and host write: taken without raising busy. Host read: the
// word passes the table read register and S_HRD into the result register.
// Frame gap: one byte per cycle for fixed bytes; per word S_W3R, S_W3H, S_W3L
// (reads) or S_F16A, S_F16B, S_F16W (writes); per coil S_CR/S_CD or S_F15R/W.
// Synchronous reset clears the table (valid bits), counters and registers.
// ----------------------------------------------------------------------------
`default_nettype none

module modbus_rtu_slave_frame_engine import mrtu_pkg::*; #(
  parameter int BUFFER_BYTES = 64,
  parameter int TABLE_WORDS  = 256
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  kind,
  input  wire logic [7:0]  rx_byte,
  input  wire logic [7:0]  table_index,
  input  wire logic [15:0] table_value,
  input  wire logic        cfg_write,
  input  wire logic        cfg_index,
  input  wire logic [7:0]  cfg_data,
  output logic             result_valid,
  output logic             result_kind,
  output logic [7:0]       tx_byte,
  output logic             frame_last,
  output logic [15:0]      read_word,
  output logic [15:0]      error_total
);

  localparam int SA_AW = $clog2(BUFFER_BYTES);
  localparam int TW_AW = $clog2(TABLE_WORDS);
  localparam int CAP   = (BUFFER_BYTES < MAX_REPLY) ? BUFFER_BYTES : MAX_REPLY;
  localparam int PCAP  = CAP - 2;
  localparam int MODM  = 65536 / TABLE_WORDS;

  // Sequencer states.
  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_HRD  = 5'd1;
  localparam logic [4:0] S_HDR  = 5'd2;
  localparam logic [4:0] S_F5R  = 5'd3;
  localparam logic [4:0] S_F5W  = 5'd4;
  localparam logic [4:0] S_F6   = 5'd5;
  localparam logic [4:0] S_F15R = 5'd6;
  localparam logic [4:0] S_F15W = 5'd7;
  localparam logic [4:0] S_F16A = 5'd8;
  localparam logic [4:0] S_F16B = 5'd9;
  localparam logic [4:0] S_F16W = 5'd10;
  localparam logic [4:0] S_W3R  = 5'd11;
  localparam logic [4:0] S_W3H  = 5'd12;
  localparam logic [4:0] S_W3L  = 5'd13;
  localparam logic [4:0] S_CR   = 5'd14;
  localparam logic [4:0] S_CD   = 5'd15;
  localparam logic [4:0] S_CLO  = 5'd16;
  localparam logic [4:0] S_CHI  = 5'd17;

  // Header byte layouts.
  localparam logic [1:0] M_EXC  = 2'd0;
  localparam logic [1:0] M_RHD  = 2'd1;
  localparam logic [1:0] M_ECHO = 2'd2;
  localparam logic [1:0] M_F16  = 2'd3;

  logic [4:0]  state;
  logic [4:0]  after_hdr;
  logic [1:0]  hdr_mode;
  logic [2:0]  hdr_idx;
  logic [2:0]  hdr_last;
  logic [7:0]  exc_code;
  logic [6:0]  tx_cnt;
  logic [15:0] crc;
  logic [16:0] loop_idx;
  logic [7:0]  acc;
  logic [7:0]  hi_byte;
  logic        rd_zero;
  logic [15:0] error_counter;
  logic [7:0]  slave_address;
  logic [7:0]  table_words_in_use;

  frame_info_t info;
  logic        accept;
  logic [7:0]  fc;
  logic [15:0] addr;
  logic [15:0] cnt;
  logic [13:0] nbytes;
  logic [15:0] coil;
  logic [16:0] idx_inc;
  logic [7:0]  chk;
  logic        unsup;
  logic        frame_ok;

  logic              put_v;
  logic [7:0]        put_b;
  logic              put_ok;
  logic [7:0]        hdr_byte;
  logic              t_rd;
  logic [TW_AW-1:0]  t_ridx;
  logic [15:0]       t_rdata;
  logic              t_wr;
  logic [TW_AW-1:0]  t_widx;
  logic [15:0]       t_wdata;
  logic              s_rd;
  logic [16:0]       s_idx;
  logic [7:0]        s_data;
  logic [7:0]        rd_byte;
  logic              coil_bit;
  logic [7:0]        acc_new;
  logic [15:0]       bit_mask;

  // Table index: low 8 bits taken modulo the table size by reciprocal.
  function automatic logic [TW_AW-1:0] tidx(input logic [7:0] v);
    logic [24:0] prod;
    logic [16:0] qt;
    logic [16:0] r;
    prod = 25'(v) * 25'(MODM);
    qt   = 17'(prod[24:16]) * 17'(TABLE_WORDS);
    r    = 17'(v) - qt;
    if (r >= 17'(TABLE_WORDS)) begin
      r = r - 17'(TABLE_WORDS);
    end
    return r[TW_AW-1:0];
  endfunction

  assign accept      = start && !busy;
  assign busy        = (state != S_IDLE);
  assign error_total = error_counter;

  mrtu_rx #(.BUFFER_BYTES(BUFFER_BYTES)) u_rx (
    .clk       (clk),
    .rst       (rst),
    .push      (accept && (kind == KIND_RX_BYTE)),
    .push_byte (rx_byte),
    .clear     (accept && (kind == KIND_GAP)),
    .rd_en     (s_rd),
    .rd_addr   (s_idx[SA_AW-1:0]),
    .rd_data   (s_data),
    .info      (info)
  );

  mrtu_table #(.TABLE_WORDS(TABLE_WORDS)) u_table (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (t_rd),
    .rd_idx  (t_ridx),
    .rd_word (t_rdata),
    .wr_en   (t_wr),
    .wr_idx  (t_widx),
    .wr_word (t_wdata)
  );

  // Request fields and the checks made at the frame gap.
  assign fc       = info.hdr[1];
  assign addr     = {info.hdr[2], info.hdr[3]};
  assign cnt      = {info.hdr[4], info.hdr[5]};
  assign nbytes   = 14'((17'(cnt) + 17'd7) >> 3);
  assign coil     = addr + loop_idx[15:0];
  assign idx_inc  = loop_idx + 17'd1;
  assign frame_ok = !info.ovf && info.len_ok && (info.hdr[0] == slave_address) && info.crc_ok;
  assign unsup    = !((fc >= FC_READ_COILS) && (fc <= FC_WRITE_REG)) &&
                    (fc != FC_WRITE_COILS) && (fc != FC_WRITE_REGS);
  assign rd_byte  = rd_zero ? 8'h00 : s_data;
  assign put_ok   = put_v && (tx_cnt < 7'(PCAP));

  always_comb begin
    if ((fc == FC_READ_COILS) || (fc == FC_READ_INPUTS) || (fc == FC_WRITE_COILS)) begin
      chk = addr[11:4] + cnt[11:4];
    end else if (fc == FC_WRITE_COIL) begin
      chk = addr[11:4];
    end else if (fc == FC_WRITE_REG) begin
      chk = addr[7:0];
    end else begin
      chk = addr[7:0] + cnt[7:0];
    end
  end

  // Fixed reply bytes by layout.
  always_comb begin
    hdr_byte = info.hdr[hdr_idx];
    unique case (hdr_mode)
      M_EXC: begin
        if (hdr_idx == 3'd0)      hdr_byte = slave_address;
        else if (hdr_idx == 3'd1) hdr_byte = fc + EXC_FLAG;
        else                      hdr_byte = exc_code;
      end
      M_RHD: begin
        if (hdr_idx == 3'd0)      hdr_byte = slave_address;
        else if (hdr_idx == 3'd1) hdr_byte = fc;
        else if ((fc == FC_READ_COILS) || (fc == FC_READ_INPUTS)) hdr_byte = nbytes[7:0];
        else                      hdr_byte = {cnt[6:0], 1'b0};
      end
      M_ECHO: hdr_byte = info.hdr[hdr_idx];
      M_F16: begin
        if (hdr_idx == 3'd4)      hdr_byte = 8'h00;
        else if (hdr_idx == 3'd5) hdr_byte = cnt[7:0];
        else                      hdr_byte = info.hdr[hdr_idx];
      end
      default: hdr_byte = info.hdr[hdr_idx];
    endcase
  end

  // Memory ports and reply byte selection for the current step.
  always_comb begin
    put_v    = 1'b0;
    put_b    = 8'h00;
    t_rd     = 1'b0;
    t_ridx   = '0;
    t_wr     = 1'b0;
    t_widx   = '0;
    t_wdata  = 16'h0000;
    s_rd     = 1'b0;
    s_idx    = '0;
    coil_bit = 1'b0;
    acc_new  = acc;
    bit_mask = 16'h0000;
    unique case (state)
      S_IDLE: begin
        if (accept && (kind == KIND_HOST_WR)) begin
          t_wr    = 1'b1;
          t_widx  = tidx(table_index);
          t_wdata = table_value;
        end
        if (accept && (kind == KIND_HOST_RD)) begin
          t_rd   = 1'b1;
          t_ridx = tidx(table_index);
        end
      end
      S_HDR: begin
        put_v = 1'b1;
        put_b = hdr_byte;
      end
      S_F5R: begin
        t_rd   = 1'b1;
        t_ridx = tidx(addr[11:4]);
      end
      S_F5W: begin
        bit_mask = 16'd1 << addr[3:0];
        t_wr     = 1'b1;
        t_widx   = tidx(addr[11:4]);
        t_wdata  = (info.hdr[4] == COIL_ON) ? (t_rdata | bit_mask) : (t_rdata & ~bit_mask);
      end
      S_F6: begin
        t_wr    = 1'b1;
        t_widx  = tidx(addr[7:0]);
        t_wdata = cnt;
      end
      S_F15R: begin
        t_rd   = 1'b1;
        t_ridx = tidx(coil[11:4]);
        s_rd   = 1'b1;
        s_idx  = 17'(FIRST_DATA) + (loop_idx >> 3);
      end
      S_F15W: begin
        bit_mask = 16'd1 << coil[3:0];
        t_wr     = 1'b1;
        t_widx   = tidx(coil[11:4]);
        t_wdata  = rd_byte[loop_idx[2:0]] ? (t_rdata | bit_mask) : (t_rdata & ~bit_mask);
      end
      S_F16A: begin
        s_rd  = 1'b1;
        s_idx = 17'(FIRST_DATA) + 17'({loop_idx[7:0], 1'b0});
      end
      S_F16B: begin
        s_rd  = 1'b1;
        s_idx = 17'(FIRST_DATA + 1) + 17'({loop_idx[7:0], 1'b0});
      end
      S_F16W: begin
        t_wr    = 1'b1;
        t_widx  = tidx(addr[7:0] + loop_idx[7:0]);
        t_wdata = {hi_byte, rd_byte};
      end
      S_W3R: begin
        t_rd   = 1'b1;
        t_ridx = tidx(addr[7:0] + loop_idx[7:0]);
      end
      S_W3H: begin
        put_v = 1'b1;
        put_b = t_rdata[15:8];
      end
      S_W3L: begin
        put_v = 1'b1;
        put_b = t_rdata[7:0];
      end
      S_CR: begin
        t_rd   = 1'b1;
        t_ridx = tidx(coil[11:4]);
      end
      S_CD: begin
        coil_bit = (loop_idx < 17'(cnt)) && t_rdata[coil[3:0]];
        acc_new  = acc | (8'(coil_bit) << loop_idx[2:0]);
        if (loop_idx[2:0] == 3'd7) begin
          put_v = 1'b1;
          put_b = acc_new;
        end
      end
      default: begin
        put_v = 1'b0;
      end
    endcase
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      slave_address      <= 8'd1;
      table_words_in_use <= 8'd255;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_SLAVE_ADDR: begin
          if ((cfg_data != 8'd0) && (cfg_data <= SLAVE_MAX)) begin
            slave_address <= cfg_data;
          end
        end
        REG_TABLE_WORDS: table_words_in_use <= cfg_data;
        default: table_words_in_use <= table_words_in_use;
      endcase
    end
  end

  // Result register and reply CRC.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= put_ok || (state == S_HRD) || (state == S_CLO) || (state == S_CHI);
    end
    if (put_ok) begin
      result_kind <= RES_TX_BYTE;
      tx_byte     <= put_b;
      frame_last  <= 1'b0;
      read_word   <= 16'h0000;
    end else if (state == S_HRD) begin
      result_kind <= RES_HOST_RD;
      tx_byte     <= 8'h00;
      frame_last  <= 1'b1;
      read_word   <= t_rdata;
    end else if (state == S_CLO || state == S_CHI) begin
      result_kind <= RES_TX_BYTE;
      tx_byte     <= (state == S_CLO) ? crc[7:0] : crc[15:8];
      frame_last  <= (state == S_CHI);
      read_word   <= 16'h0000;
    end
    if (s_rd) begin
      rd_zero <= (s_idx >= 17'(BUFFER_BYTES));
    end
    if (state == S_F16B) begin
      hi_byte <= rd_byte;
    end
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      after_hdr     <= S_CLO;
      hdr_mode      <= M_EXC;
      hdr_idx       <= 3'd0;
      hdr_last      <= 3'd2;
      exc_code      <= EXC_ILLEGAL_FUNC;
      tx_cnt        <= 7'd0;
      crc           <= CRC_INIT;
      loop_idx      <= 17'd0;
      acc           <= 8'h00;
      error_counter <= 16'h0000;
    end else begin
      if (put_ok) begin
        tx_cnt <= tx_cnt + 7'd1;
        crc    <= crc16_byte(crc, put_b);
      end
      unique case (state)
        S_IDLE: begin
          if (accept && (kind == KIND_HOST_RD)) begin
            state <= S_HRD;
          end else if (accept && (kind == KIND_GAP) && !info.len_zero) begin
            tx_cnt   <= 7'd0;
            crc      <= CRC_INIT;
            loop_idx <= 17'd0;
            acc      <= 8'h00;
            hdr_idx  <= 3'd0;
            if (!frame_ok) begin
              error_counter <= error_counter + 16'd1;
            end else if (unsup || (chk > table_words_in_use)) begin
              if (unsup) begin
                error_counter <= error_counter + 16'd1;
              end
              exc_code  <= unsup ? EXC_ILLEGAL_FUNC : EXC_ILLEGAL_ADDR;
              hdr_mode  <= M_EXC;
              hdr_last  <= 3'd2;
              after_hdr <= S_CLO;
              state     <= S_HDR;
            end else if ((fc == FC_READ_COILS) || (fc == FC_READ_INPUTS)) begin
              hdr_mode  <= M_RHD;
              hdr_last  <= 3'd2;
              after_hdr <= (cnt == 16'd0) ? S_CLO : S_CR;
              state     <= S_HDR;
            end else if ((fc == FC_READ_HOLDING) || (fc == FC_READ_INPUT_R)) begin
              hdr_mode  <= M_RHD;
              hdr_last  <= 3'd2;
              after_hdr <= (cnt[7:0] == 8'd0) ? S_CLO : S_W3R;
              state     <= S_HDR;
            end else if (fc == FC_WRITE_REGS) begin
              hdr_mode  <= M_F16;
              hdr_last  <= 3'd5;
              after_hdr <= S_CLO;
              state     <= (cnt[7:0] == 8'd0) ? S_HDR : S_F16A;
            end else begin
              hdr_mode  <= M_ECHO;
              hdr_last  <= 3'd5;
              after_hdr <= S_CLO;
              if (fc == FC_WRITE_COIL)      state <= S_F5R;
              else if (fc == FC_WRITE_REG)  state <= S_F6;
              else                          state <= (cnt == 16'd0) ? S_HDR : S_F15R;
            end
          end
        end
        S_HRD: state <= S_IDLE;
        S_HDR: begin
          hdr_idx <= hdr_idx + 3'd1;
          if (hdr_idx == hdr_last) begin
            state <= after_hdr;
          end
        end
        S_F5R: state <= S_F5W;
        S_F5W: state <= S_HDR;
        S_F6:  state <= S_HDR;
        S_F15R: state <= S_F15W;
        S_F15W: begin
          if (loop_idx[15:0] == cnt - 16'd1) begin
            state <= S_HDR;
          end else begin
            loop_idx <= idx_inc;
            state    <= S_F15R;
          end
        end
        S_F16A: state <= S_F16B;
        S_F16B: state <= S_F16W;
        S_F16W: begin
          if (loop_idx[7:0] == cnt[7:0] - 8'd1) begin
            state <= S_HDR;
          end else begin
            loop_idx <= idx_inc;
            state    <= S_F16A;
          end
        end
        S_W3R: state <= S_W3H;
        S_W3H: state <= S_W3L;
        S_W3L: begin
          if (loop_idx[7:0] == cnt[7:0] - 8'd1) begin
            state <= S_CLO;
          end else begin
            loop_idx <= idx_inc;
            state    <= S_W3R;
          end
        end
        S_CR: state <= S_CD;
        S_CD: begin
          loop_idx <= idx_inc;
          if (loop_idx[2:0] == 3'd7) begin
            acc <= 8'h00;
            // Next byte only while the byte count and the reply room allow.
            if ((14'(idx_inc >> 3) < nbytes) && (tx_cnt + 7'd1 < 7'(PCAP))) begin
              state <= S_CR;
            end else begin
              state <= S_CLO;
            end
          end else begin
            acc   <= acc_new;
            state <= S_CR;
          end
        end
        S_CLO: state <= S_CHI;
        S_CHI: state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- sim/tb_modbus_rtu_slave_frame_engine.sv -----
// ----------------------------------------------------------------------------
// tb_modbus_rtu_slave_frame_engine
// Drives received bytes, frame gaps and host table accesses into the RTU slave
// frame engine, predicts every reply byte and host read word with its own
// model of the slave, and compares each result word field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_modbus_rtu_slave_frame_engine;
  import mrtu_pkg::*;

  localparam int STORE_BYTES = 64;
  localparam int WATCH_LIMIT = 400000;
  localparam int SETTLE      = 60;

  typedef logic [7:0] byte_q_t[$];

  typedef struct {
    logic [1:0]  kind;
    logic [7:0]  data;
    logic [7:0]  index;
    logic [15:0] value;
  } word_in_t;

  typedef struct {
    logic        rkind;
    logic [7:0]  tx;
    logic        last;
    logic [15:0] rword;
    logic [15:0] errs;
  } word_out_t;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic [1:0]  kind;
  logic [7:0]  rx_byte;
  logic [7:0]  table_index;
  logic [15:0] table_value;
  logic        cfg_write;
  logic        cfg_index;
  logic [7:0]  cfg_data;
  logic        result_valid;
  logic        result_kind;
  logic [7:0]  tx_byte;
  logic        frame_last;
  logic [15:0] read_word;
  logic [15:0] error_total;

  modbus_rtu_slave_frame_engine u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .kind(kind),
    .rx_byte(rx_byte), .table_index(table_index), .table_value(table_value),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .result_valid(result_valid), .result_kind(result_kind), .tx_byte(tx_byte),
    .frame_last(frame_last), .read_word(read_word), .error_total(error_total)
  );

  // Predicted slave state.
  logic [7:0]  rx_store[STORE_BYTES];
  int          rx_count;
  bit          rx_overflow;
  logic [15:0] words[256];
  logic [15:0] drop_count;
  logic [7:0]  node_addr;
  logic [7:0]  words_limit;

  word_in_t  pending_words[$];
  word_out_t expected_results[$];
  word_in_t  cur_word;
  int        fail_count;
  int        quiet_cycles;
  int        gap_left;
  bit        gaps_on;
  bit        took_word;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic logic [15:0] crc_of(byte_q_t b);
    logic [15:0] c;
    c = CRC_INIT;
    foreach (b[i]) begin
      c = c ^ {8'h00, b[i]};
      for (int k = 0; k < 8; k++) c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  function automatic logic [7:0] store_at(int i);
    return (i < STORE_BYTES) ? rx_store[i] : 8'h00;
  endfunction

  // Reply bytes are capped so that the CRC still fits in the reply.
  function automatic void reply_put(ref byte_q_t r, input int v);
    if (r.size() + 2 < MAX_REPLY) r.push_back(v[7:0]);
  endfunction

  function automatic void reply_send(byte_q_t r);
    logic [15:0] c;
    word_out_t   o;
    c = crc_of(r);
    r.push_back(c[7:0]);
    r.push_back(c[15:8]);
    foreach (r[i]) begin
      o.rkind = RES_TX_BYTE;
      o.tx    = r[i];
      o.last  = (i == r.size() - 1);
      o.rword = 16'h0000;
      o.errs  = drop_count;
      expected_results.push_back(o);
    end
  endfunction

  // Frame-end processing: checks, table action and reply.
  function automatic void finish_frame();
    int          n, fc, addr, cnt, chk, s, m, coil, nb, v;
    logic [15:0] c;
    byte_q_t     r, body;
    n = rx_count;
    rx_count = 0;
    if (n == 0) return;
    if (rx_overflow || n < MIN_FRAME || rx_store[0] != node_addr) begin
      rx_overflow = 1'b0;
      drop_count++;
      return;
    end
    for (int i = 0; i < n - 2; i++) body.push_back(rx_store[i]);
    c = crc_of(body);
    if (rx_store[n-2] != c[7:0] || rx_store[n-1] != c[15:8]) begin
      drop_count++;
      return;
    end
    fc   = rx_store[1];
    addr = {rx_store[2], rx_store[3]};
    cnt  = {rx_store[4], rx_store[5]};
    if (!(fc >= FC_READ_COILS && fc <= FC_WRITE_REG) && fc != FC_WRITE_COILS &&
        fc != FC_WRITE_REGS) begin
      drop_count++;
      reply_put(r, node_addr); reply_put(r, fc + EXC_FLAG); reply_put(r, EXC_ILLEGAL_FUNC);
      reply_send(r);
      return;
    end
    if (fc == FC_READ_COILS || fc == FC_READ_INPUTS || fc == FC_WRITE_COILS)
      chk = addr / 16 + cnt / 16;
    else if (fc == FC_WRITE_COIL) chk = addr / 16;
    else if (fc == FC_WRITE_REG) chk = addr;
    else chk = addr + cnt;
    if ((chk & 255) > words_limit) begin
      reply_put(r, node_addr); reply_put(r, fc + EXC_FLAG); reply_put(r, EXC_ILLEGAL_ADDR);
      reply_send(r);
      return;
    end
    s = addr & 255;
    m = cnt & 255;
    case (fc)
      FC_READ_COILS, FC_READ_INPUTS: begin
        nb = (cnt + 7) / 8;
        reply_put(r, node_addr); reply_put(r, fc); reply_put(r, nb);
        for (int b = 0; b < nb && r.size() + 2 < MAX_REPLY; b++) begin
          v = 0;
          for (int k = 0; k < 8; k++) begin
            if (b * 8 + k < cnt) begin
              coil = (addr + b * 8 + k) & 16'hFFFF;
              if (words[(coil >> 4) & 255][coil & 15]) v |= 1 << k;
            end
          end
          reply_put(r, v);
        end
      end
      FC_READ_HOLDING, FC_READ_INPUT_R: begin
        reply_put(r, node_addr); reply_put(r, fc); reply_put(r, m * 2);
        for (int i = 0; i < m; i++) begin
          reply_put(r, words[(s + i) & 255][15:8]);
          reply_put(r, words[(s + i) & 255][7:0]);
        end
      end
      FC_WRITE_COIL: begin
        words[(addr >> 4) & 255][addr & 15] = (rx_store[4] == COIL_ON);
        for (int i = 0; i < 6; i++) reply_put(r, rx_store[i]);
      end
      FC_WRITE_REG: begin
        words[addr & 255] = cnt[15:0];
        for (int i = 0; i < 6; i++) reply_put(r, rx_store[i]);
      end
      FC_WRITE_COILS: begin
        for (int i = 0; i < cnt; i++) begin
          coil = (addr + i) & 16'hFFFF;
          words[(coil >> 4) & 255][coil & 15] = store_at(FIRST_DATA + i / 8)[i & 7];
        end
        for (int i = 0; i < 6; i++) reply_put(r, rx_store[i]);
      end
      default: begin
        for (int i = 0; i < m; i++)
          words[(s + i) & 255] = {store_at(FIRST_DATA + 2 * i), store_at(FIRST_DATA + 1 + 2 * i)};
        for (int i = 0; i < 4; i++) reply_put(r, rx_store[i]);
        reply_put(r, 0); reply_put(r, m);
      end
    endcase
    reply_send(r);
  endfunction

  function automatic void predict_word(word_in_t w);
    word_out_t o;
    case (w.kind)
      KIND_RX_BYTE: begin
        if (rx_count < STORE_BYTES) begin
          rx_store[rx_count] = w.data;
          rx_count++;
        end
        if (rx_count >= STORE_BYTES) rx_overflow = 1'b1;
      end
      KIND_GAP: finish_frame();
      KIND_HOST_WR: words[w.index] = w.value;
      default: begin
        o.rkind = RES_HOST_RD;
        o.tx    = 8'h00;
        o.last  = 1'b1;
        o.rword = words[w.index];
        o.errs  = drop_count;
        expected_results.push_back(o);
      end
    endcase
  endfunction

  // Monitor: checks result words, predicts accepted words, runs the watchdog.
  always @(posedge clk) begin
    word_out_t e;
    took_word = 1'b0;
    if (!rst) begin
      if (result_valid) begin
        if (expected_results.size() == 0) begin
          $error("result word with nothing expected: tx_byte %h", tx_byte);
          fail_count++;
        end else begin
          e = expected_results.pop_front();
          if (result_kind !== e.rkind) begin
            $error("result_kind expected %h got %h", e.rkind, result_kind); fail_count++;
          end
          if (tx_byte !== e.tx) begin
            $error("tx_byte expected %h got %h", e.tx, tx_byte); fail_count++;
          end
          if (frame_last !== e.last) begin
            $error("frame_last expected %h got %h", e.last, frame_last); fail_count++;
          end
          if (read_word !== e.rword) begin
            $error("read_word expected %h got %h", e.rword, read_word); fail_count++;
          end
          if (error_total !== e.errs) begin
            $error("error_total expected %h got %h", e.errs, error_total); fail_count++;
          end
        end
      end
      if (start && !busy) begin
        took_word = 1'b1;
        predict_word(cur_word);
      end
      if (took_word || result_valid) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCH_LIMIT) begin
        $display("tb_modbus_rtu_slave_frame_engine NOT OK");
        $finish;
      end
    end
  end

  // Driver: presents the next pending word at the falling edge, with idle bursts.
  always @(negedge clk) begin
    logic     next_start;
    word_in_t w;
    next_start = start && !took_word;
    w = cur_word;
    if (!rst && !next_start) begin
      if (gap_left > 0) begin
        gap_left--;
      end else if (gaps_on && $urandom_range(0, 5) == 0) begin
        gap_left = $urandom_range(1, 16) - 1;
      end else if (pending_words.size() != 0) begin
        w = pending_words.pop_front();
        next_start = 1'b1;
      end
    end
    cur_word    <= w;
    start       <= next_start;
    kind        <= w.kind;
    rx_byte     <= w.data;
    table_index <= w.index;
    table_value <= w.value;
  end

  task automatic push_word(logic [1:0] k, logic [7:0] d, logic [7:0] idx, logic [15:0] val);
    word_in_t w;
    w.kind = k; w.data = d; w.index = idx; w.value = val;
    pending_words.push_back(w);
  endtask

  // Queue a frame: bytes, CRC (optionally corrupted), then a gap.
  task automatic push_frame(byte_q_t b, bit bad_crc);
    logic [15:0] c;
    c = crc_of(b) ^ (bad_crc ? 16'h0100 : 16'h0000);
    b.push_back(c[7:0]);
    b.push_back(c[15:8]);
    foreach (b[i]) push_word(KIND_RX_BYTE, b[i], $urandom, $urandom);
    push_word(KIND_GAP, $urandom, $urandom, $urandom);
  endtask

  task automatic push_req(logic [7:0] fc, logic [15:0] a, logic [15:0] n, byte_q_t extra);
    byte_q_t b;
    b = {node_addr, fc, a[15:8], a[7:0], n[15:8], n[7:0]};
    foreach (extra[i]) b.push_back(extra[i]);
    push_frame(b, 1'b0);
  endtask

  // Wait until all words are in, all results are out and the engine settles.
  task automatic drain();
    while (pending_words.size() != 0 || start || expected_results.size() != 0 || busy)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [7:0] val);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_write <= 1'b0;
    if (idx == REG_SLAVE_ADDR) begin
      if (val != 0 && val <= SLAVE_MAX) node_addr = val;
    end else begin
      words_limit = val;
    end
  endtask

  // One random request: mostly well formed, with some broken frames and host access.
  task automatic push_random();
    int      sel, n;
    byte_q_t b, extra;
    logic [7:0] fcs[10];
    logic [7:0] fc;
    fcs = '{FC_READ_COILS, FC_READ_INPUTS, FC_READ_HOLDING, FC_READ_INPUT_R,
            FC_WRITE_COIL, FC_WRITE_REG, FC_WRITE_COILS, FC_WRITE_REGS, 8'd7, 8'd0};
    sel = $urandom_range(0, 19);
    if (sel < 3) begin
      push_word(KIND_HOST_WR, $urandom, $urandom, $urandom);
    end else if (sel < 6) begin
      push_word(KIND_HOST_RD, $urandom, $urandom, $urandom);
    end else if (sel < 8) begin
      n = $urandom_range(1, 10);
      for (int i = 0; i < n; i++) push_word(KIND_RX_BYTE, $urandom, $urandom, $urandom);
      push_word(KIND_GAP, $urandom, $urandom, $urandom);
    end else begin
      fc = (sel == 8) ? $urandom : fcs[$urandom_range(0, 9)];
      n = $urandom_range(0, 12);
      for (int i = 0; i < n; i++) extra.push_back($urandom);
      b = {(sel == 9) ? 8'($urandom) : node_addr, fc, 8'($urandom_range(0, 1) ? $urandom : 0),
           8'($urandom), 8'h00, 8'($urandom_range(0, 40))};
      if (sel == 10) b[4] = COIL_ON;
      foreach (extra[i]) b.push_back(extra[i]);
      push_frame(b, sel == 11);
    end
  endtask

  initial begin
    byte_q_t b;
    rst = 1'b1;
    start = 1'b0;
    kind = KIND_RX_BYTE;
    rx_byte = 8'h00;
    table_index = 8'h00;
    table_value = 16'h0000;
    cfg_write = 1'b0;
    cfg_index = REG_SLAVE_ADDR;
    cfg_data = 8'h00;
    cur_word = '{KIND_RX_BYTE, 8'h00, 8'h00, 16'h0000};
    fail_count = 0;
    quiet_cycles = 0;
    gap_left = 0;
    gaps_on = 1'b1;
    took_word = 1'b0;
    rx_count = 0;
    rx_overflow = 1'b0;
    drop_count = 16'h0000;
    node_addr = 8'd1;
    words_limit = 8'd255;
    foreach (rx_store[i]) rx_store[i] = 8'h00;
    foreach (words[i]) words[i] = 16'h0000;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // A full-buffer frame first writes every store entry; it is dropped as overflowed.
    for (int i = 0; i < STORE_BYTES; i++) push_word(KIND_RX_BYTE, $urandom, 8'h00, 16'h0000);
    push_word(KIND_GAP, 8'h00, 8'h00, 16'h0000);
    // Empty gap, host access at the table extremes.
    push_word(KIND_GAP, 8'hFF, 8'hFF, 16'hFFFF);
    push_word(KIND_HOST_WR, 8'h00, 8'h00, 16'hFFFF);
    push_word(KIND_HOST_WR, 8'hFF, 8'hFF, 16'h8001);
    push_word(KIND_HOST_RD, 8'h00, 8'h00, 16'h0000);
    push_word(KIND_HOST_RD, 8'h00, 8'hFF, 16'h0000);
    // Short, foreign and bad-CRC frames are dropped.
    push_frame('{8'd1, FC_READ_HOLDING, 8'h00, 8'h00}, 1'b0);
    push_frame('{8'd9, FC_READ_HOLDING, 8'h00, 8'h00, 8'h00, 8'h01}, 1'b0);
    push_frame('{8'd1, FC_READ_HOLDING, 8'h00, 8'h00, 8'h00, 8'h01}, 1'b1);
    // Every function, unsupported codes, a long reply and short write data.
    push_req(FC_READ_HOLDING, 16'h00FE, 16'h0004, b);
    push_req(FC_READ_INPUT_R, 16'h0000, 16'h0002, b);
    push_req(FC_READ_COILS, 16'h0000, 16'h0013, b);
    push_req(FC_READ_INPUTS, 16'h0FF0, 16'h0020, b);
    push_req(FC_WRITE_COIL, 16'h0025, {COIL_ON, 8'h00}, b);
    push_req(FC_WRITE_COIL, 16'h0000, 16'h0000, b);
    push_req(FC_WRITE_REG, 16'h00FF, 16'hBEEF, b);
    push_req(FC_WRITE_COILS, 16'h0013, 16'h000A, '{8'h02, 8'hA5, 8'h03});
    push_req(FC_WRITE_REGS, 16'h00FE, 16'h0003, '{8'h06, 8'h12, 8'h34, 8'h56, 8'h78});
    push_req(8'd7, 16'h0000, 16'h0000, b);
    push_req(8'hFF, 16'h0000, 16'h0000, b);
    push_req(FC_READ_HOLDING, 16'h0000, 16'h0064, b);
    push_req(FC_READ_COILS, 16'h0000, 16'hFFFF, b);
    push_req(FC_WRITE_COILS, 16'h0000, 16'hFFFF, b);
    push_req(FC_READ_HOLDING, 16'h0100, 16'h0000, b);
    drain();

    // Tightest range limit and the highest node address; out-of-range writes are ignored.
    write_reg(REG_TABLE_WORDS, 8'd0);
    write_reg(REG_SLAVE_ADDR, SLAVE_MAX);
    write_reg(REG_SLAVE_ADDR, 8'd0);
    write_reg(REG_SLAVE_ADDR, 8'd248);
    push_req(FC_READ_HOLDING, 16'h0000, 16'h0001, b);
    push_req(FC_WRITE_REG, 16'h0000, 16'h1234, b);
    push_req(FC_READ_COILS, 16'h0010, 16'h0001, b);
    for (int i = 0; i < 20; i++) push_random();
    drain();

    // Random phases, the first at the full range limit; the last runs without idle gaps.
    for (int ph = 0; ph < 3; ph++) begin
      write_reg(REG_SLAVE_ADDR, $urandom_range(1, 247));
      write_reg(REG_TABLE_WORDS, (ph == 0) ? 8'd255 : 8'($urandom_range(8, 255)));
      if (ph == 2) gaps_on = 1'b0;
      for (int i = 0; i < 12; i++) push_random();
      drain();
    end

    if (fail_count == 0) begin
      $display("tb_modbus_rtu_slave_frame_engine OK");
    end else begin
      $display("tb_modbus_rtu_slave_frame_engine NOT OK");
    end
    $finish;
  end

endmodule

`default_nettype wire
